@@ rtl/smap_pkg.sv @@
// Shared types, codes and defaults for the shaded sprite column mapper.
`timescale 1ns / 1ps
package smap_pkg;

  localparam int FRAC_BITS_DEF      = 20;
  localparam int WIDE_THRESHOLD_DEF = 256;

  localparam logic [6:0] NO_COLUMN  = 7'h7F;
  localparam logic [9:0] RUN_MAX    = 10'd1023;
  localparam logic [5:0] SHADE_TOP  = 6'd63;

  localparam logic [9:0]  VIEW_WIDTH_RST   = 10'd320;
  localparam logic [14:0] MAX_HALF_RST     = 15'd4096;
  localparam logic [11:0] NORMAL_SHADE_RST = 12'd48;
  localparam logic [5:0]  SHADE_BASE_RST   = 6'd1;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_COLUMN = 2'd1,
    FUNC_END    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_VIEW_WIDTH   = 2'd0,
    CFG_MAX_HALF     = 2'd1,
    CFG_NORMAL_SHADE = 2'd2,
    CFG_SHADE_BASE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_CHECK,
    S_DIV_STEP,
    S_DIV_SHADE,
    S_FRAC,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic start_load;
    logic col_en;
    logic end_en;
    logic span_en;
    logic reject;
    logic div_go;
    logic div_sel_shade;
    logic step_save;
    logic shade_save;
    logic frac_en;
    logic finish;
  } smap_cmd_t;

  typedef struct packed {
    logic out_free;
    logic active;
    logic reject;
    logic div_done;
  } smap_status_t;

endpackage

@@ rtl/smap_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module smap_div import smap_pkg::*; #(
  parameter int DW = FRAC_BITS_DEF + 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic [DW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [15:0]   rem;
  logic [15:0]   dsr;
  logic [16:0]   trial;
  logic          ge;

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt <= CW'(DW);
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      rem <= ge ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy && !go |-> cnt != '0)
    else $error("divider count underflow");
  assert property (@(posedge clk) disable iff (rst) done |=> !done || $past(go, 1))
    else $error("divider done longer than one cycle");

endmodule

@@ rtl/smap_ctrl.sv @@
// Controller state machine: request sequencing and sprite setup steps.
`timescale 1ns / 1ps
module smap_ctrl import smap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   func,
  output logic         in_ready,
  input  smap_status_t status,
  output smap_cmd_t    cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept && func == FUNC_START) state_next = S_SPAN;
      S_SPAN:      state_next = S_CHECK;
      S_CHECK:     state_next = status.reject ? S_IDLE : S_DIV_STEP;
      S_DIV_STEP:  if (status.div_done) state_next = S_DIV_SHADE;
      S_DIV_SHADE: if (status.div_done) state_next = S_FRAC;
      S_FRAC:      state_next = S_REPORT;
      S_REPORT:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = status.out_free;
        cmd.start_load = accept && func == FUNC_START;
        cmd.col_en     = accept && func == FUNC_COLUMN && status.active;
        cmd.end_en     = accept && func == FUNC_END && status.active;
      end
      S_SPAN: cmd.span_en = 1'b1;
      S_CHECK: begin
        cmd.reject = status.reject;
        cmd.div_go = !status.reject;
      end
      S_DIV_STEP: begin
        cmd.step_save     = status.div_done;
        cmd.div_go        = status.div_done;
        cmd.div_sel_shade = 1'b1;
      end
      S_DIV_SHADE: cmd.shade_save = status.div_done;
      S_FRAC:      cmd.frac_en = 1'b1;
      S_REPORT:    cmd.finish = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) state != S_IDLE |-> !in_ready)
    else $error("request taken outside idle");
  assert property (@(posedge clk) disable iff (rst) state == S_REPORT |=> state == S_IDLE)
    else $error("report step not followed by idle");
  assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_START |=> state == S_SPAN)
    else $error("start request did not begin setup");

endmodule

@@ rtl/smap_dp.sv @@
// Datapath: config registers, sprite setup math, column walk and result register.
`timescale 1ns / 1ps
module smap_dp import smap_pkg::*; #(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int WIDE_THRESHOLD = WIDE_THRESHOLD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  smap_cmd_t          cmd,
  output smap_status_t       status,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic signed [11:0] x_center,
  input  logic [15:0]        height,
  input  logic [5:0]         left_pix,
  input  logic [5:0]         right_pix,
  input  logic signed [7:0]  lighting,
  input  logic [15:0]        wall_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic               visible,
  output logic [9:0]         first_col,
  output logic [9:0]         last_col,
  output logic [5:0]         shade_index,
  output logic [9:0]         run_x,
  output logic [9:0]         run_width,
  output logic [5:0]         tex_column,
  output logic [13:0]        post_height
);

  localparam int SW  = FRAC_BITS + 17;     // span sum width
  localparam int XW  = 17;                 // screen column before clipping
  localparam int DW  = FRAC_BITS + 9;      // divider width
  localparam int QW  = FRAC_BITS + 8;      // step width
  localparam int PW  = XW + QW;            // clipped-left fraction product
  localparam int CRW = 32 - FRAC_BITS;     // integer part of texel position

  // configuration
  logic [9:0]  view_width;
  logic [14:0] max_half_height;
  logic [11:0] normal_shade;
  logic [5:0]  shade_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width      <= VIEW_WIDTH_RST;
      max_half_height <= MAX_HALF_RST;
      normal_shade    <= NORMAL_SHADE_RST;
      shade_base      <= SHADE_BASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VIEW_WIDTH:   view_width      <= cfg_data[9:0];
        CFG_MAX_HALF:     max_half_height <= cfg_data[14:0];
        CFG_NORMAL_SHADE: normal_shade    <= cfg_data[11:0];
        CFG_SHADE_BASE:   shade_base      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // start request, height doubles as the saved sprite height
  logic signed [11:0] xc_q;
  logic [15:0]        h_q;
  logic [5:0]         lp_q, rp_q;
  logic signed [7:0]  light_q;

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      xc_q    <= x_center;
      h_q     <= height;
      lp_q    <= left_pix;
      rp_q    <= right_pix;
      light_q <= lighting;
    end
  end

  // span: floor((xc<<F) - (h<<(F-3)) + half + pix*h<<(F-8)) >> F
  logic [21:0]        lph, rph;
  logic signed [SW-1:0] base_s, x1_sum, x2_sum;
  logic signed [XW-1:0] x1_q, x2_q, vw_s;
  logic               hbad_q;

  assign lph    = 22'(lp_q) * 22'(h_q);
  assign rph    = 22'(rp_q) * 22'(h_q);
  assign base_s = (SW'(xc_q) <<< FRAC_BITS)
                - (signed'(SW'(h_q)) <<< (FRAC_BITS - 3))
                + (SW'(1) <<< (FRAC_BITS - 1));
  assign x1_sum = base_s + (signed'(SW'(lph)) <<< (FRAC_BITS - 8));
  assign x2_sum = base_s + (signed'(SW'(rph)) <<< (FRAC_BITS - 8));
  assign vw_s   = signed'(XW'(view_width));

  always_ff @(posedge clk) begin
    if (cmd.span_en) begin
      x1_q   <= XW'(x1_sum >>> FRAC_BITS);
      x2_q   <= XW'(x2_sum >>> FRAC_BITS);
      hbad_q <= (h_q[15:1] > max_half_height) || (h_q[15:1] == 15'd0);
    end
  end

  // shared divider: texel step, then shade steps
  logic [DW-1:0] div_dividend, div_quo;
  logic [15:0]   div_divisor;
  logic [11:0]   ns_eff;
  logic [18:0]   shade_num;
  logic          div_done;

  assign ns_eff       = (normal_shade == 12'd0) ? 12'd1 : normal_shade;
  assign shade_num    = 19'(h_q[15:3]) * 19'(SHADE_TOP);
  assign div_dividend = cmd.div_sel_shade ? DW'(shade_num) : (DW'(1) << QW);
  assign div_divisor  = cmd.div_sel_shade ? 16'(ns_eff) : h_q;

  smap_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .done     (div_done)
  );

  logic [31:0] step_q;   // also the live texel step while active
  logic [18:0] shq;
  logic [31:0] frac_q;
  logic [XW-1:0] neg_x1;
  logic [PW-1:0] frac_prod;

  assign neg_x1    = XW'(-x1_q);
  assign frac_prod = PW'(neg_x1) * PW'(step_q[QW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.step_save)  step_q <= 32'(div_quo);
    if (cmd.shade_save) shq    <= 19'(div_quo);
    if (cmd.frac_en) begin
      if (x1_q[XW-1]) begin
        frac_q <= (frac_prod[PW-1:32] != '0) ? 32'hFFFF_FFFF : frac_prod[31:0];
      end else begin
        frac_q <= step_q >> 1;
      end
    end
  end

  // report fields
  logic [9:0]        rep_first, rep_last;
  logic signed [20:0] sh_s;
  logic [5:0]        rep_shade;

  assign rep_first = x1_q[XW-1] ? 10'd0 : x1_q[9:0];
  assign rep_last  = (x2_q >= vw_s) ? view_width - 10'd1 : x2_q[9:0];
  assign sh_s      = signed'(21'(shade_base)) - signed'(21'(shq)) + 21'(light_q);

  always_comb begin
    if (sh_s < 0)             rep_shade = 6'd0;
    else if (sh_s > 21'sd63)  rep_shade = SHADE_TOP;
    else                      rep_shade = sh_s[5:0];
  end

  // column walk state
  logic          active, wide_mode;
  logic [6:0]    prev_column, prev_next;
  logic [9:0]    run_count, rc_next;
  logic [9:0]    cur_x, run_start, rs_next;
  logic [31:0]   tex_position;
  logic [5:0]    tex_limit;
  logic [CRW-1:0] col_raw;
  logic [5:0]    col;
  logic          hidden, pending;
  logic          emit;
  logic [9:0]    e_x, e_w;
  logic [5:0]    e_col;

  assign col_raw = tex_position[31:FRAC_BITS];
  assign col     = (col_raw > CRW'(tex_limit)) ? tex_limit : col_raw[5:0];
  assign hidden  = wall_height > h_q;
  assign pending = !prev_column[6];

  always_comb begin
    emit      = 1'b0;
    e_x       = run_start;
    e_w       = run_count;
    e_col     = prev_column[5:0];
    prev_next = prev_column;
    rc_next   = run_count;
    rs_next   = run_start;
    if (cmd.col_en) begin
      if (!wide_mode) begin
        emit  = !hidden;
        e_x   = cur_x;
        e_w   = 10'd1;
        e_col = col;
      end else if (hidden) begin
        emit      = pending;
        rc_next   = 10'd1;
        prev_next = NO_COLUMN;
      end else if ({1'b0, col} == prev_column) begin
        if (run_count < RUN_MAX) rc_next = run_count + 10'd1;
      end else begin
        emit      = pending;
        rs_next   = cur_x;
        rc_next   = 10'd1;
        prev_next = {1'b0, col};
      end
    end else if (cmd.end_en) begin
      emit = wide_mode && pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      wide_mode   <= 1'b0;
      prev_column <= NO_COLUMN;
      run_count   <= 10'd1;
    end else begin
      if (cmd.start_load || cmd.end_en) begin
        active      <= 1'b0;
        prev_column <= NO_COLUMN;
        run_count   <= 10'd1;
      end
      if (cmd.finish) begin
        active    <= 1'b1;
        wide_mode <= h_q > 16'(WIDE_THRESHOLD);
      end
      if (cmd.col_en) begin
        prev_column <= prev_next;
        run_count   <= rc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cur_x        <= rep_first;
      tex_position <= frac_q;
      tex_limit    <= (rp_q >= lp_q) ? rp_q - lp_q : 6'd0;
      run_start    <= 10'd0;
    end else if (cmd.col_en) begin
      cur_x        <= cur_x + 10'd1;
      tex_position <= tex_position + step_q;
      run_start    <= rs_next;
    end
  end

  // result register
  logic out_load;

  assign out_load = cmd.finish || cmd.reject || emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind        <= emit;
      visible     <= cmd.finish;
      first_col   <= cmd.finish ? rep_first : 10'd0;
      last_col    <= cmd.finish ? rep_last : 10'd0;
      shade_index <= cmd.finish ? rep_shade : 6'd0;
      run_x       <= emit ? e_x : 10'd0;
      run_width   <= emit ? e_w : 10'd0;
      tex_column  <= emit ? e_col : 6'd0;
      post_height <= emit ? h_q[15:2] : 14'd0;
    end
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.active   = active;
  assign status.reject   = hbad_q || (x1_q >= vw_s) || x2_q[XW-1];
  assign status.div_done = div_done;

  assert property (@(posedge clk) disable iff (rst) out_load |-> !out_valid || out_ready)
    else $error("result register overwritten");
  assert property (@(posedge clk) disable iff (rst) !prev_column[6] |-> active)
    else $error("pending run while idle");
  assert property (@(posedge clk) disable iff (rst) run_count != 10'd0)
    else $error("run width zero");

endmodule

@@ rtl/shaded_sprite_column_mapper.sv @@
// Top level of the shaded sprite column mapper.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready): func selects start sprite, next column or
//  end sprite. A start request carries x_center, height, left_pix, right_pix and
//  lighting; a column request carries wall_height of the next screen column.
//  Output channel (out_valid/out_ready): kind 0 is the setup report for a start,
//  kind 1 a draw run. Each request gives zero or one result.
//  Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..3 writes
//  view_width, max_half_height, normal_shade, shade_base. Write only when idle.
// Timing:
//  One column or end request can be accepted every cycle while the receiver
//  keeps up. The result shows the cycle after acceptance.
//  A start request runs the setup sequence: span, check, two passes of the
//  bit-serial divider, clip fraction and report; a rejected sprite reports
//  from the check step. No new request is taken during setup.
// Reset: synchronous; clears config to defaults, drops any sprite in progress.
// Stall: the single result register holds until taken; in_ready stays low
//  while it is full and not being drained.
module shaded_sprite_column_mapper import smap_pkg::*; #(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int WIDE_THRESHOLD = WIDE_THRESHOLD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [11:0] x_center,
  input  logic [15:0]        height,
  input  logic [5:0]         left_pix,
  input  logic [5:0]         right_pix,
  input  logic signed [7:0]  lighting,
  input  logic [15:0]        wall_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic               visible,
  output logic [9:0]         first_col,
  output logic [9:0]         last_col,
  output logic [5:0]         shade_index,
  output logic [9:0]         run_x,
  output logic [9:0]         run_width,
  output logic [5:0]         tex_column,
  output logic [13:0]        post_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  smap_cmd_t    cmd;
  smap_status_t status;

  // config writes are always accepted and land in the next cycle
  assign cfg_ready = 1'b1;

  smap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  smap_dp #(
    .FRAC_BITS      (FRAC_BITS),
    .WIDE_THRESHOLD (WIDE_THRESHOLD)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .x_center    (x_center),
    .height      (height),
    .left_pix    (left_pix),
    .right_pix   (right_pix),
    .lighting    (lighting),
    .wall_height (wall_height),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .visible     (visible),
    .first_col   (first_col),
    .last_col    (last_col),
    .shade_index (shade_index),
    .run_x       (run_x),
    .run_width   (run_width),
    .tex_column  (tex_column),
    .post_height (post_height)
  );

endmodule

@@ tb/shaded_sprite_column_mapper_test.sv @@
// Self-checking test of the sprite column mapper: random and directed requests.
`timescale 1ns / 1ps
module shaded_sprite_column_mapper_test;
  import smap_pkg::*;

  // One observed or predicted result, all output fields.
  typedef struct packed {
    logic       kind;
    logic       visible;
    logic [9:0] first_col;
    logic [9:0] last_col;
    logic [5:0] shade_index;
    logic [9:0] run_x;
    logic [9:0] run_width;
    logic [5:0] tex_column;
    logic [13:0] post_height;
  } sprite_result_t;

  // Mirror of the mapper: config, sprite state and the queue of pending results.
  class sprite_scoreboard;
    logic [9:0]  view_w;
    logic [14:0] max_half;
    logic [11:0] norm_shade;
    logic [5:0]  base_shade;
    bit          wide, busy;
    logic [9:0]  pos_x, run_first;
    logic [31:0] tex_pos, tex_inc;
    logic [5:0]  tex_max;
    logic [6:0]  last_tex;
    logic [9:0]  run_len;
    logic [15:0] sprite_h;
    sprite_result_t pending[$];
    int errors, results, runs, shown;

    function void reset_state();
      view_w = VIEW_WIDTH_RST; max_half = MAX_HALF_RST;
      norm_shade = NORMAL_SHADE_RST; base_shade = SHADE_BASE_RST;
      wide = 0; busy = 0; pos_x = 0; tex_pos = 0; tex_inc = 0; tex_max = 0;
      last_tex = NO_COLUMN; run_first = 0; run_len = 1; sprite_h = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [14:0] data);
      case (idx)
        CFG_VIEW_WIDTH:   view_w = data[9:0];
        CFG_MAX_HALF:     max_half = data;
        CFG_NORMAL_SHADE: norm_shade = data[11:0];
        default:          base_shade = data[5:0];
      endcase
    endfunction

    // Floor of a fixed-point value; arithmetic shift floors for negatives.
    function longint floor_fx(longint v);
      return v >>> FRAC_BITS_DEF;
    endfunction

    function void emit_run(logic [9:0] x, logic [9:0] w, logic [5:0] col);
      sprite_result_t r;
      r = '0;
      r.kind = 1; r.run_x = x; r.run_width = w; r.tex_column = col;
      r.post_height = sprite_h[15:2];
      pending.push_back(r);
    endfunction

    function void note_request(logic [1:0] fn, logic signed [11:0] xc, logic [15:0] h,
                               logic [5:0] lp, logic [5:0] rp, logic signed [7:0] lt,
                               logic [15:0] wall);
      sprite_result_t r;
      longint xs, xcen, x1, x2, sh, frac;
      longint unsigned step, ns;
      logic [9:0] x;
      logic [31:0] col;
      r = '0;
      if (fn == FUNC_START) begin
        busy = 0; last_tex = NO_COLUMN; run_len = 1;
        if ((h >> 1) > max_half || (h >> 1) == 0) begin
          pending.push_back(r);
          return;
        end
        xs = longint'(h) << (FRAC_BITS_DEF - 8);
        xcen = (longint'(xc) <<< FRAC_BITS_DEF) - (longint'(h) << (FRAC_BITS_DEF - 3))
             + (longint'(1) << (FRAC_BITS_DEF - 1));
        x1 = floor_fx(xcen + longint'(lp) * xs);
        x2 = floor_fx(xcen + longint'(rp) * xs);
        if (x1 >= longint'(view_w) || x2 < 0) begin
          pending.push_back(r);
          return;
        end
        step = (longint'(256) << FRAC_BITS_DEF) / h;
        if (x1 < 0) begin
          frac = -x1 * longint'(step);
          if (frac > 64'hFFFF_FFFF) frac = 64'hFFFF_FFFF;
          x1 = 0;
        end else frac = step >> 1;
        if (x2 >= longint'(view_w)) x2 = longint'(view_w) - 1;
        ns = (norm_shade == 0) ? 1 : norm_shade;
        sh = longint'(base_shade) - longint'((63 * longint'(h >> 3)) / ns) + lt;
        if (sh < 0) sh = 0;
        if (sh > 63) sh = 63;
        wide = h > WIDE_THRESHOLD_DEF; busy = 1;
        pos_x = x1[9:0]; tex_pos = frac[31:0]; tex_inc = step[31:0];
        tex_max = (rp >= lp) ? rp - lp : 6'd0;
        sprite_h = h; run_first = 0;
        r.visible = 1; r.first_col = x1[9:0]; r.last_col = x2[9:0];
        r.shade_index = sh[5:0];
        pending.push_back(r);
        return;
      end
      if (!busy) return;
      if (fn == FUNC_COLUMN) begin
        x = pos_x;
        col = tex_pos >> FRAC_BITS_DEF;
        if (col > tex_max) col = tex_max;
        pos_x = pos_x + 10'd1; tex_pos = tex_pos + tex_inc;
        if (!wide) begin
          if (wall <= sprite_h) emit_run(x, 10'd1, col[5:0]);
          return;
        end
        if (wall > sprite_h) begin
          // occluded: close any open run
          if (!last_tex[6]) emit_run(run_first, run_len, last_tex[5:0]);
          run_len = 1; last_tex = NO_COLUMN;
          return;
        end
        if ({1'b0, col[5:0]} == last_tex) begin
          if (run_len < RUN_MAX) run_len++;
          return;
        end
        if (!last_tex[6]) emit_run(run_first, run_len, last_tex[5:0]);
        run_first = x; run_len = 1; last_tex = {1'b0, col[5:0]};
      end else if (fn == FUNC_END) begin
        if (wide && !last_tex[6]) emit_run(run_first, run_len, last_tex[5:0]);
        busy = 0; last_tex = NO_COLUMN; run_len = 1;
      end
    endfunction

    function void check_result(sprite_result_t got);
      sprite_result_t want;
      results++;
      if (got.kind) runs++; else if (got.visible) shown++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        if (got.kind !== want.kind) $display("  kind exp %0d act %0d", want.kind, got.kind);
        if (got.first_col !== want.first_col || got.last_col !== want.last_col)
          $display("  cols exp %0d..%0d act %0d..%0d", want.first_col, want.last_col,
                   got.first_col, got.last_col);
        if (got.shade_index !== want.shade_index)
          $display("  shade exp %0d act %0d", want.shade_index, got.shade_index);
        if (got.run_x !== want.run_x || got.run_width !== want.run_width)
          $display("  run exp %0d+%0d act %0d+%0d", want.run_x, want.run_width,
                   got.run_x, got.run_width);
        if (got.tex_column !== want.tex_column)
          $display("  tex exp %0d act %0d", want.tex_column, got.tex_column);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] func;
  logic signed [11:0] x_center;
  logic [15:0] height;
  logic [5:0] left_pix, right_pix;
  logic signed [7:0] lighting;
  logic [15:0] wall_height;
  logic out_valid, out_ready;
  logic kind, visible;
  logic [9:0] first_col, last_col, run_x, run_width;
  logic [5:0] shade_index, tex_column;
  logic [13:0] post_height;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  shaded_sprite_column_mapper u_dut (.*);

  sprite_scoreboard sb;
  bit idle_on;        // random gaps enabled
  int stall_left;     // receiver stall burst
  int quiet_cycles;   // watchdog
  int requests_sent;
  bit timed_out;

  localparam int WATCHDOG = 20000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts on out_ready; results checked on handshake.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result({kind, visible, first_col, last_col, shade_index,
                         run_x, run_width, tex_column, post_height});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 19) - 1;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  // Watchdog: counts cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("shaded_sprite_column_mapper_test: FAIL");
      $finish;
    end
  end

  // One request: optional gap, then hold valid until accepted.
  task automatic send(logic [1:0] fn, logic signed [11:0] xc, logic [15:0] h,
                      logic [5:0] lp, logic [5:0] rp, logic signed [7:0] lt,
                      logic [15:0] wall);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1; func <= fn; x_center <= xc; height <= h; left_pix <= lp;
    right_pix <= rp; lighting <= lt; wall_height <= wall;
    do @(posedge clk); while (!in_ready);
    sb.note_request(fn, xc, h, lp, rp, lt, wall);
    requests_sent++;
  endtask

  task automatic release_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Drain all pending results, then allow the block to settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [14:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // A random sprite: start, its columns (sometimes too many), then usually end.
  task automatic random_sprite();
    logic [15:0] h;
    logic [15:0] wall;
    int ncol, pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) h = 16'($urandom_range(2, 256));
    else if (pick < 8) h = 16'($urandom_range(257, 3000));
    else if (pick == 8) h = 16'($urandom_range(0, 65535));
    else h = 16'($urandom_range(0, 1));
    send(FUNC_START, 12'($urandom_range(0, 4095)), h, 6'($urandom_range(0, 63)),
         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), 0);
    ncol = $urandom_range(0, 24);
    for (int i = 0; i < ncol; i++) begin
      // walls around the sprite height so occlusion flips often
      if ($urandom_range(0, 3) == 0) wall = 16'($urandom_range(0, 65535));
      else wall = 16'(h + $urandom_range(0, 40) - 30);
      send(FUNC_COLUMN, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
           0, 0, 0, wall);
    end
    if ($urandom_range(0, 5) != 0)
      send(FUNC_END, 0, 0, 0, 0, 0, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    logic [14:0] vw [4];
    sb = new();
    sb.reset_state();
    rst = 1; in_valid = 0; func = FUNC_START; x_center = 0; height = 0;
    left_pix = 0; right_pix = 0; lighting = 0; wall_height = 0;
    cfg_valid = 0; cfg_index = CFG_VIEW_WIDTH; cfg_data = 0;
    idle_on = 0; requests_sent = 0; timed_out = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: idle column/end, unused code, height limits, reversed extents,
    // off-screen sides, restart while active, narrow and wide sprites.
    send(FUNC_COLUMN, 0, 0, 0, 0, 0, 0);
    send(FUNC_END, 0, 0, 0, 0, 0, 0);
    send(2'd3, -12'sd2048, 16'hFFFF, 63, 63, -8'sd128, 16'hFFFF);
    send(FUNC_START, 0, 0, 0, 63, 0, 0);
    send(FUNC_START, 100, 16'hFFFF, 0, 63, 127, 0);
    send(FUNC_START, 2047, 200, 0, 63, 0, 0);
    send(FUNC_START, -12'sd2048, 200, 0, 63, 0, 0);
    send(FUNC_START, 160, 120, 40, 10, -8'sd128, 0);
    send(FUNC_COLUMN, 0, 0, 0, 0, 0, 0);
    send(FUNC_START, 5, 2, 0, 63, 127, 0);
    send(FUNC_COLUMN, 0, 0, 0, 0, 0, 16'hFFFF);
    send(FUNC_COLUMN, 0, 0, 0, 0, 0, 0);
    send(FUNC_START, 0, 600, 0, 63, 0, 0);
    for (int i = 0; i < 8; i++) send(FUNC_COLUMN, 0, 0, 0, 0, 0, (i == 5) ? 16'hFFFF : 16'h0);
    send(FUNC_END, 0, 0, 0, 0, 0, 0);
    send(2'd3, 0, 0, 0, 0, 0, 0);
    release_input();
    drain();

    // Random phases, each under a different register setting, extremes included.
    vw[0] = 15'd320; vw[1] = 15'd1; vw[2] = 15'd1023; vw[3] = 15'd0;
    idle_on = 1;
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_VIEW_WIDTH, (ph < 4) ? vw[ph] : 15'($urandom_range(1, 1023)));
      write_cfg(CFG_MAX_HALF, (ph == 1) ? 15'd1 : (ph == 2) ? 15'd32767 :
                (ph == 3) ? 15'd0 : 15'($urandom_range(200, 4096)));
      write_cfg(CFG_NORMAL_SHADE, (ph == 1) ? 15'd1 : (ph == 2) ? 15'd4095 :
                (ph == 3) ? 15'd0 : 15'($urandom_range(1, 200)));
      write_cfg(CFG_SHADE_BASE, (ph == 1) ? 15'd0 : (ph == 2) ? 15'd63 :
                15'($urandom_range(0, 63)));
      if (ph == 7) idle_on = 0;   // final stretch without gaps
      while (requests_sent < 25 + (ph + 1) * 235) begin
        if ($urandom_range(0, 15) == 0)
          send(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
               16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
               6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 65535)));
        else random_sprite();
      end
      release_input();
      drain();
    end

    $display("covered %0d requests, %0d results: %0d visible setups, %0d draw runs",
             requests_sent, sb.results, sb.shown, sb.runs);
    $display("register settings swept over extremes of all four registers");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("shaded_sprite_column_mapper_test: PASS");
    else
      $display("shaded_sprite_column_mapper_test: FAIL");
    $finish;
  end

endmodule

@@ shaded_sprite_column_mapper.f @@
rtl/smap_pkg.sv
rtl/smap_div.sv
rtl/smap_ctrl.sv
rtl/smap_dp.sv
rtl/shaded_sprite_column_mapper.sv
tb/shaded_sprite_column_mapper_test.sv
